// ===== src/assert_macros.svh =====
// Assertion helpers for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define PCNT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("pcnt check failed");

// Clocked assertion that is also checked during reset.
`define PCNT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pcnt check failed");

`endif

// ===== src/pcnt_pkg.sv =====
// ----------------------------------------------------------------------------
// pcnt_pkg
// Shared types and constants of the cylinder neighbor test unit.
// ----------------------------------------------------------------------------
package pcnt_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned RAD_W   = 36;
  localparam int unsigned HH_W    = 17;
  localparam int unsigned CFG_W   = 36;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned FRAC_W  = 14;
  localparam int unsigned PIPE_LAT = 5;

  localparam logic [CIDX_W-1:0] CFG_AXIS_X      = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_AXIS_Y      = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_AXIS_Z      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_RADIUS_SQ   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_HALF_HEIGHT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } pcnt_state_e;

  // One pair tag moving along the test pipeline.
  typedef struct packed {
    logic             vld;
    logic             pass;
    logic [IDX_W-1:0] idx;
  } pcnt_tag_t;

endpackage

// ===== src/pcnt_cell.sv =====
// ----------------------------------------------------------------------------
// pcnt_cell
// One stored point of the ring; loads its neighbor's point when shifted.
// ----------------------------------------------------------------------------
module pcnt_cell #(
  parameter int unsigned W = 48
) (
  input  logic         clk_i,
  input  logic         shift_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pt_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pt_q <= d_i;
    end
  end

  assign q_o = pt_q;

endmodule

// ===== src/pcnt_pair_test.sv =====
// ----------------------------------------------------------------------------
// pcnt_pair_test
// Five-stage pipeline: difference, products, sums, projection square, compare.
// ----------------------------------------------------------------------------
module pcnt_pair_test
  import pcnt_pkg::*;
#(
  parameter int unsigned C    = 16,
  parameter int unsigned DIMS = 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pcnt_tag_t                tag_i,
  input  logic signed [C-1:0]      ax_i, ay_i, az_i,   // earlier point
  input  logic signed [C-1:0]      bx_i, by_i, bz_i,   // new point
  input  logic signed [AXIS_W-1:0] axis_x_i, axis_y_i, axis_z_i,
  input  logic [RAD_W-1:0]         radius_sq_i,
  input  logic [HH_W-1:0]          half_height_i,
  output pcnt_tag_t                tag_o
);

  localparam int unsigned DW  = C + 1;
  localparam int unsigned PW  = DW + AXIS_W;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned QW  = 2 * DW;
  localparam int unsigned LW  = QW + 2;
  localparam int unsigned MW  = SW - FRAC_W;
  localparam int unsigned P2W = 2 * MW;
  localparam int unsigned CW  = ((P2W > LW) ? P2W : LW) + 2 > RAD_W + 1
                              ? ((P2W > LW) ? P2W : LW) + 2 : RAD_W + 1;

  pcnt_tag_t t1_q, t2_q, t3_q, t4_q, t5_q;

  // stage 1: difference
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  always_ff @(posedge clk_i) begin
    dx_q <= DW'(ax_i) - DW'(bx_i);
    dy_q <= DW'(ay_i) - DW'(by_i);
    dz_q <= (DIMS == 3) ? (DW'(az_i) - DW'(bz_i)) : '0;
  end

  // stage 2: products
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic signed [QW-1:0] qx_q, qy_q, qz_q;
  always_ff @(posedge clk_i) begin
    px_q <= PW'(dx_q) * PW'(axis_x_i);
    py_q <= PW'(dy_q) * PW'(axis_y_i);
    pz_q <= PW'(dz_q) * PW'(axis_z_i);
    qx_q <= QW'(dx_q) * QW'(dx_q);
    qy_q <= QW'(dy_q) * QW'(dy_q);
    qz_q <= QW'(dz_q) * QW'(dz_q);
  end

  // stage 3: sums
  logic signed [SW-1:0] dot_q;
  logic signed [LW-1:0] len_q;
  always_ff @(posedge clk_i) begin
    dot_q <= SW'(px_q) + SW'(py_q) + SW'(pz_q);
    len_q <= LW'(qx_q) + LW'(qy_q) + LW'(qz_q);
  end

  // stage 4: projection magnitude and its square
  logic [SW-1:0]        mag;
  logic [MW-1:0]        proj;
  logic [P2W-1:0]       pp_q;
  logic signed [LW-1:0] len4_q;
  logic                 hh_ok_q;
  assign mag  = dot_q[SW-1] ? SW'(-dot_q) : SW'(dot_q);
  assign proj = mag[SW-1:FRAC_W];
  always_ff @(posedge clk_i) begin
    pp_q    <= P2W'(proj) * P2W'(proj);
    len4_q  <= len_q;
    hh_ok_q <= ((MW > HH_W ? MW : HH_W)'(proj))
               <= ((MW > HH_W ? MW : HH_W)'(half_height_i));
  end

  // stage 5: perpendicular distance compare
  logic signed [CW-1:0] perp;
  logic                 pass_q;
  assign perp = CW'(len4_q) - CW'($signed({1'b0, pp_q}));
  always_ff @(posedge clk_i) begin
    pass_q <= hh_ok_q && (perp <= $signed(CW'(radius_sq_i)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
      t5_q <= '0;
    end else begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      t3_q <= t2_q;
      t4_q <= t3_q;
      t5_q <= t4_q;
    end
  end

  always_comb begin
    tag_o      = t5_q;
    tag_o.pass = pass_q;
  end

endmodule

// ===== src/pairwise_cylinder_neighbor_test_unit.sv =====
// ----------------------------------------------------------------------------
// pairwise_cylinder_neighbor_test_unit
// Stores points of a set and reports every earlier point that lies inside a
// cylinder of configured axis, radius and half height around each new point.
//
//   channel | signals                                   | flow
//   --------+-------------------------------------------+------------------
//   point   | start_i, busy_o, start_set_i, coord_*_i   | start & !busy
//   result  | result_valid_o, earlier/new_index_o, ...  | strobe, no stall
//   config  | cfg_we_i, cfg_idx_i, cfg_wdata_i          | write on cfg_we_i
//
// Each point makes the ring of stored points turn once, one pair entering
// the test pipeline per cycle, then the pipeline drains; no new point is
// taken until then. A point that finds the set full is answered with an
// overflow result in the cycle after its transfer. Reset empties the set;
// stored coordinates are not cleared.
// Results cannot be stalled: each strobe lasts one cycle.
// ----------------------------------------------------------------------------
module pairwise_cylinder_neighbor_test_unit
  import pcnt_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned DIMENSIONS = 3,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // point channel
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     start_set_i,
  input  logic signed [IN_W-1:0]   coord_x_i,
  input  logic signed [IN_W-1:0]   coord_y_i,
  input  logic signed [IN_W-1:0]   coord_z_i,
  // result channel
  output logic                     result_valid_o,
  output logic [IDX_W-1:0]         earlier_index_o,
  output logic [IDX_W-1:0]         new_index_o,
  output logic                     last_o,
  output logic                     overflow_o,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CIDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned PTW = 3 * C;
  localparam int unsigned CNW = $clog2(MAX_POINTS + 1);
  localparam int unsigned DCW = $clog2(PIPE_LAT + 1);

  // ---------------- configuration registers ----------------
  logic signed [AXIS_W-1:0] axis_x_q, axis_y_q, axis_z_q;
  logic [RAD_W-1:0]         radius_sq_q;
  logic [HH_W-1:0]          half_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q      <= AXIS_W'(16'sd16384);
      axis_y_q      <= '0;
      axis_z_q      <= '0;
      radius_sq_q   <= '0;
      half_height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AXIS_X:      axis_x_q      <= cfg_wdata_i[AXIS_W-1:0];
        CFG_AXIS_Y:      axis_y_q      <= cfg_wdata_i[AXIS_W-1:0];
        CFG_AXIS_Z:      axis_z_q      <= cfg_wdata_i[AXIS_W-1:0];
        CFG_RADIUS_SQ:   radius_sq_q   <= cfg_wdata_i[RAD_W-1:0];
        CFG_HALF_HEIGHT: half_height_q <= cfg_wdata_i[HH_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------- control ----------------
  pcnt_state_e     state_q, state_d;
  logic [CNW-1:0]  count_q, count_d;    // stored points
  logic [CNW-1:0]  step_q, step_d;      // ring position during a turn
  logic [DCW-1:0]  dcnt_q, dcnt_d;      // drain cycles
  logic [PTW-1:0]  newpt_q;             // arriving point, packed z:y:x
  logic [CNW-1:0]  eff_count;
  logic            accept;
  logic            full;

  // coordinates are taken from their low COORD_BITS bits
  logic [C-1:0] in_x, in_y, in_z;
  assign in_x = C'($unsigned(coord_x_i));
  assign in_y = C'($unsigned(coord_y_i));
  assign in_z = (DIMENSIONS == 3) ? C'($unsigned(coord_z_i)) : '0;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign eff_count = start_set_i ? '0 : count_q;
  assign full      = (eff_count == CNW'(MAX_POINTS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && !full) state_d = ST_RUN;
      ST_RUN:   if (step_q == CNW'(MAX_POINTS - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (dcnt_q == DCW'(PIPE_LAT)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // count changes only on a set restart at transfer and when the drain ends,
  // so every result of a point carries the same new index
  always_comb begin
    count_d = count_q;
    step_d  = step_q;
    dcnt_d  = dcnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) count_d = eff_count;
        step_d = '0;
        dcnt_d = '0;
      end
      ST_RUN: begin
        step_d = step_q + 1'b1;
      end
      ST_DRAIN: begin
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(PIPE_LAT)) count_d = count_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) newpt_q <= {in_z, in_y, in_x};
  end

  assign busy_o = (state_q != ST_IDLE);

  // ---------------- ring of stored points ----------------
  // Head cell holds point number step_q; the ring turns once per point and
  // the new point enters at the tail on the step equal to the old count.
  logic [PTW-1:0] cell_q [MAX_POINTS];
  logic           shift;
  assign shift = (state_q == ST_RUN);

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    logic [PTW-1:0] cell_d;
    if (k == MAX_POINTS - 1) begin : g_tail
      assign cell_d = (step_q == count_q) ? newpt_q : cell_q[0];
    end else begin : g_body
      assign cell_d = cell_q[k+1];
    end
    pcnt_cell #(.W(PTW)) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .d_i    (cell_d),
      .q_o    (cell_q[k])
    );
  end

  // ---------------- pair test ----------------
  pcnt_tag_t tag_in, tag_out;
  assign tag_in.vld  = shift && (step_q < count_q);
  assign tag_in.pass = 1'b0;
  assign tag_in.idx  = IDX_W'(step_q + 1'b1);

  pcnt_pair_test #(.C(C), .DIMS(DIMENSIONS)) u_test (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (tag_in),
    .ax_i         (cell_q[0][C-1:0]),
    .ay_i         (cell_q[0][2*C-1:C]),
    .az_i         (cell_q[0][3*C-1:2*C]),
    .bx_i         (newpt_q[C-1:0]),
    .by_i         (newpt_q[2*C-1:C]),
    .bz_i         (newpt_q[3*C-1:2*C]),
    .axis_x_i     (axis_x_q),
    .axis_y_i     (axis_y_q),
    .axis_z_i     (axis_z_q),
    .radius_sq_i  (radius_sq_q),
    .half_height_i(half_height_q),
    .tag_o        (tag_out)
  );

  // ---------------- result ordering ----------------
  // A passing pair is held back until the next one shows up (or the drain
  // ends), so the final transfer of a point can carry last.
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic             flush;
  logic             hit;
  logic             res_v_q, res_last_q, res_ovf_q;
  logic [IDX_W-1:0] res_e_q, res_n_q;
  logic [IDX_W-1:0] new_idx;

  assign hit     = tag_out.vld && tag_out.pass;
  assign flush   = (state_q == ST_DRAIN) && (dcnt_q == DCW'(PIPE_LAT));
  assign new_idx = IDX_W'(count_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= (accept && full) || (hit && pend_q) || (flush && pend_q);
      if (hit) begin
        pend_q <= 1'b1;
      end else if (flush) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) pend_idx_q <= tag_out.idx;
    if (accept && full) begin
      res_e_q    <= '0;
      res_n_q    <= '0;
      res_last_q <= 1'b1;
      res_ovf_q  <= 1'b1;
    end else begin
      res_e_q    <= pend_idx_q;
      res_n_q    <= new_idx;
      res_last_q <= flush;
      res_ovf_q  <= 1'b0;
    end
  end

  assign result_valid_o  = res_v_q;
  assign earlier_index_o = res_e_q;
  assign new_index_o     = res_n_q;
  assign last_o          = res_last_q;
  assign overflow_o      = res_ovf_q;

endmodule

// ===== src/pcnt_checker.sv =====
// ----------------------------------------------------------------------------
// pcnt_checker
// Port-level checks of the cylinder neighbor test unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcnt_checker
  import pcnt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             busy_o,
  input logic             result_valid_o,
  input logic [IDX_W-1:0] earlier_index_o,
  input logic [IDX_W-1:0] new_index_o,
  input logic             last_o,
  input logic             overflow_o
);

  `PCNT_ASSERT(a_ovf_last, clk_i, rst_ni, (result_valid_o && overflow_o) |-> last_o)
  `PCNT_ASSERT(a_ovf_zero, clk_i, rst_ni,
    (result_valid_o && overflow_o) |-> (earlier_index_o == '0 && new_index_o == '0))
  `PCNT_ASSERT(a_pair_order, clk_i, rst_ni,
    (result_valid_o && !overflow_o) |-> (earlier_index_o != '0 && earlier_index_o != new_index_o))
  `PCNT_ASSERT(a_more_follow, clk_i, rst_ni, (result_valid_o && !last_o) |-> busy_o)
  `PCNT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !result_valid_o)

endmodule

bind pairwise_cylinder_neighbor_test_unit pcnt_checker u_pcnt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .earlier_index_o(earlier_index_o),
  .new_index_o    (new_index_o),
  .last_o         (last_o),
  .overflow_o     (overflow_o)
);

// ===== verif/pcnt_neighbor_checker.sv =====
// ----------------------------------------------------------------------------
// pcnt_neighbor_checker
// Watches the point, config and result channels of the cylinder neighbor
// unit, predicts the neighbor pairs of each point and checks them in order.
// ----------------------------------------------------------------------------
module pcnt_neighbor_checker
  import pcnt_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic                   start_set_i,
  input  logic signed [IN_W-1:0] coord_x_i,
  input  logic signed [IN_W-1:0] coord_y_i,
  input  logic signed [IN_W-1:0] coord_z_i,
  input  logic                   result_valid_i,
  input  logic [IDX_W-1:0]       earlier_index_i,
  input  logic [IDX_W-1:0]       new_index_i,
  input  logic                   last_i,
  input  logic                   overflow_i,
  input  logic                   cfg_we_i,
  input  logic [CIDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] earlier;
    logic [IDX_W-1:0] newer;
    logic             last;
    logic             ovf;
  } pair_t;

  pair_t pair_q[$];

  logic signed [AXIS_W-1:0] ax, ay, az;
  logic [RAD_W-1:0]         rad_sq;
  logic [HH_W-1:0]          half_h;
  logic signed [IN_W-1:0]   set_x[MAX_POINTS];
  logic signed [IN_W-1:0]   set_y[MAX_POINTS];
  logic signed [IN_W-1:0]   set_z[MAX_POINTS];
  int unsigned              set_len;

  assign pending_o = pair_q.size();

  function automatic bit in_cylinder(int unsigned k, logic signed [IN_W-1:0] x,
                                     logic signed [IN_W-1:0] y,
                                     logic signed [IN_W-1:0] z);
    longint dx, dy, dz, dot, len, mag, p;
    dx  = longint'(set_x[k]) - longint'(x);
    dy  = longint'(set_y[k]) - longint'(y);
    dz  = longint'(set_z[k]) - longint'(z);
    dot = dx * longint'(ax) + dy * longint'(ay) + dz * longint'(az);
    len = dx * dx + dy * dy + dz * dz;
    mag = (dot < 0) ? -dot : dot;
    p   = mag >> FRAC_W;
    // non-unit axis can make the perpendicular term negative: signed compare
    return (len - p * p <= longint'({28'd0, rad_sq})) &&
           (p <= longint'({47'd0, half_h}));
  endfunction

  task automatic predict_point();
    int n;
    pair_t r;
    n = 0;
    if (start_set_i) set_len = 0;
    if (set_len >= MAX_POINTS) begin
      r = '{earlier: '0, newer: '0, last: 1'b1, ovf: 1'b1};
      pair_q = {pair_q, r};
    end else begin
      for (int unsigned k = 0; k < set_len; k++) begin
        if (in_cylinder(k, coord_x_i, coord_y_i, coord_z_i)) begin
          r = '{earlier: IDX_W'(k + 1), newer: IDX_W'(set_len + 1), last: 1'b0,
                ovf: 1'b0};
          pair_q = {pair_q, r};
          n++;
        end
      end
      if (n > 0) pair_q[pair_q.size() - 1].last = 1'b1;
      set_x[set_len] = coord_x_i;
      set_y[set_len] = coord_y_i;
      set_z[set_len] = coord_z_i;
      set_len++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pair_t got, want;
    if (!rst_ni) begin
      ax      <= 16'sd16384;
      ay      <= '0;
      az      <= '0;
      rad_sq  <= '0;
      half_h  <= '0;
      set_len = 0;
      pair_q.delete();
      fail_count_o <= 0;
    end else begin
      if (result_valid_i) begin
        got = '{earlier: earlier_index_i, newer: new_index_i, last: last_i,
                ovf: overflow_i};
        if (pair_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected result %p", $realtime, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pair_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display("%0t: result mismatch exp %p got %p", $realtime, want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AXIS_X:      ax     <= cfg_wdata_i[AXIS_W-1:0];
          CFG_AXIS_Y:      ay     <= cfg_wdata_i[AXIS_W-1:0];
          CFG_AXIS_Z:      az     <= cfg_wdata_i[AXIS_W-1:0];
          CFG_RADIUS_SQ:   rad_sq <= cfg_wdata_i[RAD_W-1:0];
          CFG_HALF_HEIGHT: half_h <= cfg_wdata_i[HH_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) predict_point();
    end
  end

endmodule

// ===== verif/pairwise_cylinder_neighbor_test_unit_tb.sv =====
// ----------------------------------------------------------------------------
// pairwise_cylinder_neighbor_test_unit_tb
// Drives point sets through the neighbor unit under several cylinder
// settings; a side checker predicts every pair and reports the failures.
// ----------------------------------------------------------------------------
module pairwise_cylinder_neighbor_test_unit_tb;
  import pcnt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS = 32;
  // index past the register list, writes there must be dropped
  localparam logic [CIDX_W-1:0] CFG_NONE = 3'd7;
  localparam int unsigned DRAIN_CYC = NPTS + PIPE_LAT + 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_POINTS = 180;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   start_set = 1'b0;
  logic signed [IN_W-1:0] cx = '0, cy = '0, cz = '0;
  logic                   res_vld;
  logic [IDX_W-1:0]       res_earlier, res_new;
  logic                   res_last, res_ovf;
  logic                   cfg_we = 1'b0;
  logic [CIDX_W-1:0]      cfg_idx = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  int                     fails, pending;
  int unsigned            cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pairwise_cylinder_neighbor_test_unit #(.MAX_POINTS(NPTS)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .start_i(start), .busy_o(busy), .start_set_i(start_set),
    .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz),
    .result_valid_o(res_vld), .earlier_index_o(res_earlier),
    .new_index_o(res_new), .last_o(res_last), .overflow_o(res_ovf),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  pcnt_neighbor_checker #(.MAX_POINTS(NPTS)) u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .start_i(start), .busy_i(busy), .start_set_i(start_set),
    .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz),
    .result_valid_i(res_vld), .earlier_index_i(res_earlier),
    .new_index_i(res_new), .last_i(res_last), .overflow_i(res_ovf),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fails), .pending_o(pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Point transfer: hold start until a negedge shows busy low, so the
  // transfer happens at the following posedge. Entered and left at a posedge.
  task automatic send_point(logic ss, logic signed [IN_W-1:0] x,
                            logic signed [IN_W-1:0] y, logic signed [IN_W-1:0] z);
    start     <= 1'b1;
    start_set <= ss;
    cx <= x;
    cy <= y;
    cz <= z;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Random gap between bursts; zero keeps start high for back-to-back.
  task automatic maybe_gap();
    int unsigned g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (g != 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Wait until all expected pairs arrived and the unit has gone quiet.
  // Points without neighbors give no result, hence the extra drain time.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Whole register set, written back-to-back while the unit is idle.
  task automatic set_cylinder(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [RAD_W-1:0] r2, logic [HH_W-1:0] hh);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_AXIS_X;      cfg_wdata <= CFG_W'(x);  @(posedge clk);
    cfg_idx <= CFG_AXIS_Y;      cfg_wdata <= CFG_W'(y);  @(posedge clk);
    cfg_idx <= CFG_AXIS_Z;      cfg_wdata <= CFG_W'(z);  @(posedge clk);
    cfg_idx <= CFG_RADIUS_SQ;   cfg_wdata <= CFG_W'(r2); @(posedge clk);
    cfg_idx <= CFG_HALF_HEIGHT; cfg_wdata <= CFG_W'(hh); @(posedge clk);
    // stray write outside the register map, must change nothing
    cfg_idx <= CFG_NONE; cfg_wdata <= CFG_W'({$urandom, $urandom}); @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random cylinder sized to the point spread so pairs pass often enough.
  task automatic random_cylinder(int unsigned spread);
    logic [15:0] x, y, z;
    int unsigned sel;
    sel = $urandom_range(0, 6);
    case (sel)
      0: begin x = 16'sd16384;  y = 0;             z = 0;            end
      1: begin x = 0;           y = -16'sd16384;   z = 0;            end
      2: begin x = 0;           y = 0;             z = -16'sd16384;  end
      3: begin x = 16'sd11585;  y = -16'sd11585;   z = 0;            end
      4: begin x = 16'sd9459;   y = 16'sd9459;     z = 16'sd9459;    end
      default: begin  // non-unit
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end
    endcase
    if ($urandom_range(0, 7) == 0)
      set_cylinder(x, y, z, {RAD_W{1'b1}}, {HH_W{1'b1}});  // largest radius and half height
    else if ($urandom_range(0, 7) == 0)
      set_cylinder(x, y, z, '0, '0);
    else
      set_cylinder(x, y, z, RAD_W'($urandom_range(0, 3 * spread * spread)),
                   HH_W'($urandom_range(0, 2 * spread)));
  endtask

  initial begin
    int unsigned done, set_size, spread, since_cfg;
    int cxc, cyc, czc;
    logic signed [IN_W-1:0] px, py, pz;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero radius and height, only coincident points pair.
    send_point(1'b1, 0, 0, 0);
    send_point(1'b0, 0, 0, 0);
    send_point(1'b0, 1, 0, 0);
    send_point(1'b0, 0, 0, 0);
    drain();

    // Small cylinder along x; field extremes and a fresh set mid-stream.
    set_cylinder(16'sd16384, 0, 0, 36'd4, 17'd2);
    send_point(1'b1, 16'sh7fff, -16'sh8000, 16'sh7fff);
    send_point(1'b0, 16'sh7ffe, -16'sh8000, 16'sh7fff);
    send_point(1'b0, -16'sh8000, 16'sh7fff, -16'sh8000);
    send_point(1'b0, 16'sh7fff, -16'sh7fff, 16'sh7ffe);
    send_point(1'b1, 5, 5, 5);
    send_point(1'b0, 8, 5, 5);
    send_point(1'b0, 5, 7, 5);
    drain();

    // Non-unit axis: the perpendicular term goes negative for long pairs.
    set_cylinder(16'sh7fff, 16'sh7fff, -16'sh8000, 36'd0, {HH_W{1'b1}});
    send_point(1'b1, -16'sh8000, -16'sh8000, 16'sh7fff);
    send_point(1'b0, 16'sh7fff, 16'sh7fff, -16'sh8000);
    send_point(1'b0, 0, 0, 0);
    drain();

    // Max cylinder: every pair passes, then the set overflows.
    set_cylinder(0, 0, 16'sd16384, {RAD_W{1'b1}}, {HH_W{1'b1}});
    for (int i = 0; i < 34; i++) begin
      send_point(i == 0, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
      maybe_gap();
    end
    drain();

    // Random part: clustered sets with occasional noise and oversized sets.
    done = 0;
    since_cfg = 99;
    spread = 20;
    while (done < RANDOM_POINTS) begin
      if (since_cfg > $urandom_range(20, 60)) begin
        drain();
        case ($urandom_range(0, 2))
          0: spread = 3;
          1: spread = 40;
          default: spread = 400;
        endcase
        random_cylinder(spread);
        since_cfg = 0;
      end
      set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 35)
                                             : $urandom_range(2, 12);
      cxc = $urandom_range(0, 60000) - 30000;
      cyc = $urandom_range(0, 60000) - 30000;
      czc = $urandom_range(0, 60000) - 30000;
      for (int unsigned k = 0; k < set_size; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          px = IN_W'($urandom);
          py = IN_W'($urandom);
          pz = IN_W'($urandom);
        end else begin
          px = IN_W'(cxc + $urandom_range(0, 2 * spread) - spread);
          py = IN_W'(cyc + $urandom_range(0, 2 * spread) - spread);
          pz = IN_W'(czc + $urandom_range(0, 2 * spread) - spread);
        end
        // a stray set restart now and then breaks the sequence
        send_point(k == 0 || $urandom_range(0, 19) == 0, px, py, pz);
        done++;
        since_cfg++;
        if (done == RANDOM_POINTS / 2) begin
          // hold off until every pending pair is out
          start <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
          @(posedge clk);
        end else if (since_cfg > 10 || done > 30) begin
          maybe_gap();
        end
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
